// ===== src/cordic_sign_magnitude_defines.svh =====
// Assertion macros shared by the CORDIC sign-magnitude block.
`ifndef CORDIC_SIGN_MAGNITUDE_DEFINES_SVH
`define CORDIC_SIGN_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cms_pkg.sv =====
// Types, constants and the sign-magnitude adder for the CORDIC block.
`default_nettype none
package cms_pkg;

   localparam int MAG_BITS = 24;
   localparam int COUNT_BITS = 5;
   localparam int ATAN_ENTRIES = 24;
   localparam int MAX_ITERATIONS_DEFAULT = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(16);

   localparam logic [MAG_BITS-1:0] ANGLE_ROM [ATAN_ENTRIES] = '{
      24'h00C910, 24'h0076B2, 24'h003EB7, 24'h001FD6,
      24'h000FFB, 24'h0007FF, 24'h000400, 24'h000200,
      24'h000100, 24'h000080, 24'h000040, 24'h000020,
      24'h000010, 24'h000008, 24'h000004, 24'h000002,
      24'h000001, 24'h000000, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'h000000
   };

   localparam logic ACTION_VECTORING = 1'b0;
   localparam logic ACTION_ROTATION = 1'b1;

   typedef struct packed {
      logic                action;
      logic                x_sign;
      logic [MAG_BITS-1:0] x_mag;
      logic                y_sign;
      logic [MAG_BITS-1:0] y_mag;
      logic                z_sign;
      logic [MAG_BITS-1:0] z_mag;
   } cms_req_type;

   typedef struct packed {
      logic                x_out_sign;
      logic [MAG_BITS-1:0] x_out_mag;
      logic                y_out_sign;
      logic [MAG_BITS-1:0] y_out_mag;
      logic                z_out_sign;
      logic [MAG_BITS-1:0] z_out_mag;
      logic                overflow;
   } cms_rsp_type;

   typedef struct packed {
      logic                action;
      logic                x_sign;
      logic [MAG_BITS-1:0] x_mag;
      logic                y_sign;
      logic [MAG_BITS-1:0] y_mag;
      logic                z_sign;
      logic [MAG_BITS-1:0] z_mag;
      logic                overflow;
   } cms_vec_type;

   typedef struct packed {
      logic                  advance;
      logic [COUNT_BITS-1:0] count;
   } cms_ctl_type;

   typedef struct packed {
      logic                sign;
      logic [MAG_BITS-1:0] mag;
      logic                ovf;
   } cms_sum_type;

   // On equal magnitudes with opposite signs the first operand's sign wins.
   function automatic cms_sum_type cms_sm_add(logic s1, logic [MAG_BITS-1:0] m1,
                                              logic s2, logic [MAG_BITS-1:0] m2);
      cms_sum_type r;
      logic [MAG_BITS:0] sum;
      sum = {1'b0, m1} + {1'b0, m2};
      r.ovf = 1'b0;
      if (s1 != s2) begin
         if (m1 >= m2) begin
            r.mag = m1 - m2;
            r.sign = s1;
         end else begin
            r.mag = m2 - m1;
            r.sign = s2;
         end
      end else begin
         r.mag = sum[MAG_BITS-1:0];
         r.sign = s1;
         r.ovf = sum[MAG_BITS];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/cms_stage.sv =====
// One pipelined micro-rotation stage of the CORDIC block.
`default_nettype none
module cms_stage #(
   parameter int STAGE_INDEX = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cms_pkg::cms_ctl_type ctl,
   input  wire logic                 valid_in,
   input  wire cms_pkg::cms_vec_type data_in,
   output logic                      valid_out,
   output cms_pkg::cms_vec_type      data_out
);
   import cms_pkg::*;

   localparam logic [MAG_BITS-1:0] ANGLE = ANGLE_ROM[STAGE_INDEX];
   localparam logic [COUNT_BITS-1:0] INDEX = COUNT_BITS'(STAGE_INDEX);

   logic        valid_ff;
   cms_vec_type data_ff;
   cms_vec_type data_in_next;
   cms_sum_type x_sum;
   cms_sum_type y_sum;
   cms_sum_type z_sum;
   logic [MAG_BITS-1:0] x_shift;
   logic [MAG_BITS-1:0] y_shift;
   logic first;
   logic active;

   always_comb begin
      x_shift = data_in.x_mag >> STAGE_INDEX;
      y_shift = data_in.y_mag >> STAGE_INDEX;
      active = ctl.count > INDEX;
      if (data_in.action == ACTION_ROTATION) begin
         first = !data_in.z_sign;
      end else begin
         first = data_in.y_sign;
      end
      if (first) begin
         x_sum = cms_sm_add(data_in.x_sign, data_in.x_mag, !data_in.y_sign, y_shift);
         y_sum = cms_sm_add(data_in.y_sign, data_in.y_mag, data_in.x_sign, x_shift);
         z_sum = cms_sm_add(data_in.z_sign, data_in.z_mag, 1'b1, ANGLE);
      end else begin
         x_sum = cms_sm_add(data_in.x_sign, data_in.x_mag, data_in.y_sign, y_shift);
         y_sum = cms_sm_add(data_in.y_sign, data_in.y_mag, !data_in.x_sign, x_shift);
         z_sum = cms_sm_add(data_in.z_sign, data_in.z_mag, 1'b0, ANGLE);
      end
      data_in_next = data_in;
      if (active) begin
         data_in_next.x_sign = x_sum.sign;
         data_in_next.x_mag = x_sum.mag;
         data_in_next.y_sign = y_sum.sign;
         data_in_next.y_mag = y_sum.mag;
         data_in_next.z_sign = z_sum.sign;
         data_in_next.z_mag = z_sum.mag;
         data_in_next.overflow = data_in.overflow | x_sum.ovf | y_sum.ovf | z_sum.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         data_ff <= data_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign data_out = data_ff;

endmodule
`default_nettype wire

// ===== src/cordic_sign_magnitude.sv =====
// Top level of the pipelined circular CORDIC on sign-magnitude 8.16 values.
// The req channel takes one item per cycle while the pipeline advances:
// a mode and x, y, z as sign and magnitude. The rsp channel returns the
// final x, y, z and an overflow flag for each item, in the order the items
// were taken. Gain is not removed. Each micro-rotation has its own register
// stage, and a new item can enter every cycle while the pipeline advances.
// The csr channel writes the iteration count (always ready); stages past the
// count pass their item through unchanged. The count must only be changed
// while no item is in flight; the block itself does not enforce this.
// The whole pipeline advances together: when the rsp side holds a result
// that is not taken, every stage holds and req_ready drops in the same
// cycle, so nothing is lost or repeated. Empty stages hold as well, so
// bubbles stay in place while the receiver stalls.
// Synchronous reset empties the pipeline and sets the count to 16.
`default_nettype none
module cordic_sign_magnitude #(
   parameter int MAX_ITERATIONS = cms_pkg::MAX_ITERATIONS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire cms_pkg::cms_req_type             req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output cms_pkg::cms_rsp_type                  rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [cms_pkg::COUNT_BITS-1:0]   csr_data
);
   import cms_pkg::*;

   `include "cordic_sign_magnitude_defines.svh"

   logic [COUNT_BITS-1:0] iteration_count_ff;
   logic [COUNT_BITS-1:0] iteration_count_in;
   cms_ctl_type ctl;
   logic        stage_valid [MAX_ITERATIONS+1];
   cms_vec_type stage_data [MAX_ITERATIONS+1];
   cms_vec_type last;

   assign csr_ready = 1'b1;
   assign iteration_count_in = (csr_valid && csr_ready) ? csr_data : iteration_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iteration_count_ff <= COUNT_RESET;
      end else begin
         iteration_count_ff <= iteration_count_in;
      end
   end

   assign ctl.advance = !stage_valid[MAX_ITERATIONS] || rsp_ready;
   assign ctl.count = iteration_count_ff;
   assign req_ready = ctl.advance;

   always_comb begin
      stage_valid[0] = req_valid;
      stage_data[0].action = req_data.action;
      stage_data[0].x_sign = req_data.x_sign;
      stage_data[0].x_mag = req_data.x_mag;
      stage_data[0].y_sign = req_data.y_sign;
      stage_data[0].y_mag = req_data.y_mag;
      stage_data[0].z_sign = req_data.z_sign;
      stage_data[0].z_mag = req_data.z_mag;
      stage_data[0].overflow = 1'b0;
   end

   for (genvar j = 0; j < MAX_ITERATIONS; j++) begin : g_stage
      cms_stage #(
         .STAGE_INDEX(j)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .valid_in (stage_valid[j]),
         .data_in  (stage_data[j]),
         .valid_out(stage_valid[j+1]),
         .data_out (stage_data[j+1])
      );
   end

   assign last = stage_data[MAX_ITERATIONS];
   assign rsp_valid = stage_valid[MAX_ITERATIONS];

   always_comb begin
      rsp_data.x_out_sign = last.x_sign;
      rsp_data.x_out_mag = last.x_mag;
      rsp_data.y_out_sign = last.y_sign;
      rsp_data.y_out_mag = last.y_mag;
      rsp_data.z_out_sign = last.z_sign;
      rsp_data.z_out_mag = last.z_mag;
      rsp_data.overflow = last.overflow;
   end

   `CMS_ASSERT_NOW(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready, "req taken during a stall")
   `CMS_ASSERT_NOW(a_empty_takes_req, !rsp_valid, req_ready, "req blocked with empty output")
   `CMS_ASSERT_NEXT(a_csr_write, csr_valid && csr_ready, iteration_count_ff == $past(csr_data), "iteration count write lost")

endmodule
`default_nettype wire
